FILE: sv/btaa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btaa_pkg: shared types and constants of the tile atlas allocator
// Mode and status codes, controller command and status structs.
// ----------------------------------------------------------------------------
package btaa_pkg;

	localparam int KEY_W   = 64;
	localparam int SIZE_W  = 16;
	localparam int TILE_W  = 8;
	localparam int EDGE_W  = 13;
	localparam int COORD_W = 12;
	localparam int STAT_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 13;
	localparam int GEN_W   = 32;
	localparam int SLOT_W  = 25;
	localparam int TPR_W   = 13;

	localparam logic [1:0] MODE_ACQUIRE = 2'd0;
	localparam logic [1:0] MODE_FIND    = 2'd1;
	localparam logic [1:0] MODE_ADVANCE = 2'd2;
	localparam logic [1:0] MODE_CLEAR   = 2'd3;

	localparam logic [STAT_W-1:0] ST_PLACED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_STORED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_ROOM  = 3'd2;
	localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STAT_W-1:0] ST_DONE     = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_TILE0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd5;

	localparam logic [COORD_W-1:0] COORD_MAX = 12'd4095;

	typedef struct packed {
		logic scan_start;   // begin a scan over all entries
		logic div_start;    // begin a division
		logic ld_clear;     // start clearing valid bits
	} btaa_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
	} btaa_stat_t;

endpackage
`default_nettype wire

FILE: sv/btaa_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btaa_in_if / btaa_out_if: valid-ready channels of the tile atlas allocator
// One request per valid and ready edge.
// ----------------------------------------------------------------------------
interface btaa_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] glyph_key;
	logic [15:0] size_fixed;
	modport source (output valid, mode, glyph_key, size_fixed, input ready);
	modport sink   (input valid, mode, glyph_key, size_fixed, output ready);
endinterface

interface btaa_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [1:0]  bucket_index;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [7:0]  tile_edge;
	logic        grew_flag;
	logic [31:0] current_generation;
	logic [12:0] bucket_edge;
	modport source (output valid, status, bucket_index, pos_x, pos_y, tile_edge,
		grew_flag, current_generation, bucket_edge, input ready);
	modport sink   (input valid, status, bucket_index, pos_x, pos_y, tile_edge,
		grew_flag, current_generation, bucket_edge, output ready);
endinterface
`default_nettype wire

FILE: sv/btaa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btaa_div: restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module btaa_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo,
	output logic [DEN_W-1:0]      rem
);
	localparam int CNT_W = $clog2(NUM_W + 1);
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign rem = rem_q[DEN_W-1:0];
endmodule
`default_nettype wire

FILE: sv/btaa_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btaa_store: entry store and scan engine
// Holds tiles in memories, scans every entry once per request for a key hit,
// the first free entry and the eviction candidate of a bucket.
// ----------------------------------------------------------------------------
module btaa_store
	import btaa_pkg::*;
#(
	parameter int ENTRY_COUNT = 256,
	parameter int STAMP_BITS  = 32,
	parameter int BKT_W       = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 scan_start,
	input  wire logic                 clear_all,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [BKT_W-1:0]     bkt,
	output logic                      scan_done,
	output logic                      hit_found,
	output logic [$clog2(ENTRY_COUNT)-1:0] hit_idx,
	output logic                      free_found,
	output logic [$clog2(ENTRY_COUNT)-1:0] free_idx,
	output logic                      vic_found,
	output logic [$clog2(ENTRY_COUNT)-1:0] vic_idx,
	output logic [STAMP_BITS-1:0]     vic_stamp,
	output logic [COORD_W-1:0]        vic_x,
	output logic [COORD_W-1:0]        vic_y,
	output logic [COORD_W-1:0]        hit_x,
	output logic [COORD_W-1:0]        hit_y,
	input  wire logic                 wr_en,
	input  wire logic [$clog2(ENTRY_COUNT)-1:0] wr_idx,
	input  wire logic [COORD_W-1:0]   wr_x,
	input  wire logic [COORD_W-1:0]   wr_y,
	input  wire logic [STAMP_BITS-1:0] wr_stamp,
	input  wire logic                 stamp_en,
	input  wire logic [$clog2(ENTRY_COUNT)-1:0] stamp_idx,
	input  wire logic                 inval_en,
	input  wire logic [$clog2(ENTRY_COUNT)-1:0] inval_idx
);
	localparam int IDX_W = $clog2(ENTRY_COUNT);
	localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
	localparam int REC_W = KEY_W + BKT_W + 2 * COORD_W + STAMP_BITS;

	logic [REC_W-1:0]      mem_q [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0] valid_q;

	logic             rd_busy_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [REC_W-1:0] rec_s1;
	logic             vld_s1;

	logic [KEY_W-1:0]      r_key;
	logic [BKT_W-1:0]      r_bkt;
	logic [COORD_W-1:0]    r_x;
	logic [COORD_W-1:0]    r_y;
	logic [STAMP_BITS-1:0] r_stamp;

	assign {r_key, r_bkt, r_x, r_y, r_stamp} = rec_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_idx] <= {key, bkt, wr_x, wr_y, wr_stamp};
		else if (stamp_en)
			mem_q[stamp_idx][STAMP_BITS-1:0] <= wr_stamp;
		rec_s1 <= mem_q[rd_cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear_all) begin
			valid_q <= '0;
		end else begin
			if (inval_en)
				valid_q[inval_idx] <= 1'b0;
			if (wr_en)
				valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_busy_q <= 1'b0;
			rd_cnt_q  <= '0;
			chk_s1    <= 1'b0;
			scan_done <= 1'b0;
		end else begin
			scan_done <= chk_s1 && !rd_busy_q;
			chk_s1    <= rd_busy_q;
			if (scan_start) begin
				rd_busy_q <= 1'b1;
				rd_cnt_q  <= '0;
			end else if (rd_busy_q) begin
				if (rd_cnt_q == CNT_W'(ENTRY_COUNT - 1))
					rd_busy_q <= 1'b0;
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IDX_W-1:0];
		vld_s1 <= valid_q[rd_cnt_q[IDX_W-1:0]];
		if (scan_start) begin
			hit_found  <= 1'b0;
			free_found <= 1'b0;
			vic_found  <= 1'b0;
		end else if (chk_s1) begin
			if (vld_s1 && r_key == key && r_bkt == bkt && !hit_found) begin
				hit_found <= 1'b1;
				hit_idx   <= idx_s1;
				hit_x     <= r_x;
				hit_y     <= r_y;
			end
			if (!vld_s1 && !free_found) begin
				free_found <= 1'b1;
				free_idx   <= idx_s1;
			end
			if (vld_s1 && r_bkt == bkt && (!vic_found || r_stamp < vic_stamp)) begin
				vic_found <= 1'b1;
				vic_idx   <= idx_s1;
				vic_stamp <= r_stamp;
				vic_x     <= r_x;
				vic_y     <= r_y;
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/btaa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btaa_ctrl: request sequencer
// Steps through lookup, capacity, eviction, growth and placement of an acquire request.
// ----------------------------------------------------------------------------
module btaa_ctrl
	import btaa_pkg::*;
#(
	parameter int ENTRY_COUNT  = 256,
	parameter int STAMP_BITS   = 32,
	parameter int BUCKET_COUNT = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic [1:0] in_mode,
	input  wire logic out_fire,
	input  wire logic hit_found,
	input  wire logic free_found,
	input  wire logic vic_evict,
	input  wire logic tile_zero,
	input  wire logic cap_zero,
	input  wire logic slot_full,
	input  wire logic grow_ok,
	input  wire logic tpr_zero,
	input  btaa_stat_t stat,
	output btaa_cmd_t  cmd,
	output logic       busy,
	output logic       out_valid,
	output logic [4:0] step
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_SCAN  = 5'd1;
	localparam logic [4:0] S_TPR   = 5'd2;  // edge / tile
	localparam logic [4:0] S_CAP   = 5'd3;  // check capacity
	localparam logic [4:0] S_VY    = 5'd4;  // victim y / tile
	localparam logic [4:0] S_VX    = 5'd5;  // victim x / tile
	localparam logic [4:0] S_GROW  = 5'd6;  // grown edge / tile
	localparam logic [4:0] S_TPR2  = 5'd7;  // edge / tile for placement
	localparam logic [4:0] S_SLOT  = 5'd8;  // slot / tpr
	localparam logic [4:0] S_MULY  = 5'd9;
	localparam logic [4:0] S_WRITE = 5'd10;
	localparam logic [4:0] S_FAIL  = 5'd11;
	localparam logic [4:0] S_DONE  = 5'd12;
	localparam logic [4:0] S_OUT   = 5'd13;
	localparam logic [4:0] S_HIT   = 5'd14;

	logic [4:0] st_q;
	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			mode_q <= MODE_ACQUIRE;
		end else begin
			case (st_q)
				S_IDLE: if (in_fire) begin
					mode_q <= in_mode;
					st_q   <= (in_mode inside {MODE_ACQUIRE, MODE_FIND}) ? S_SCAN : S_DONE;
				end
				S_SCAN: if (stat.scan_done) begin
					if (hit_found)
						st_q <= S_HIT;
					else if (mode_q == MODE_FIND)
						st_q <= S_DONE;
					else if (tile_zero)
						st_q <= S_FAIL;
					else
						st_q <= S_TPR;
				end
				S_TPR: if (stat.div_done) st_q <= S_CAP;
				S_CAP: begin
					if (!slot_full)
						st_q <= free_found ? S_TPR2 : S_FAIL;
					else if (vic_evict)
						st_q <= S_VY;
					else if (grow_ok && free_found)
						st_q <= S_GROW;
					else
						st_q <= S_FAIL;
				end
				S_VY:   if (stat.div_done) st_q <= S_VX;
				S_VX:   if (stat.div_done) st_q <= S_TPR2;
				S_GROW: if (stat.div_done) st_q <= S_TPR2;
				S_TPR2: if (stat.div_done) st_q <= S_SLOT;
				S_SLOT: begin
					if (tpr_zero)
						st_q <= S_FAIL;
					else if (stat.div_done)
						st_q <= S_MULY;
				end
				S_MULY:  st_q <= S_WRITE;
				S_WRITE: st_q <= S_OUT;
				S_FAIL:  st_q <= S_OUT;
				S_DONE:  st_q <= S_OUT;
				S_HIT:   st_q <= S_OUT;
				S_OUT:   if (out_fire) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.scan_start = (st_q == S_IDLE) && in_fire &&
			(in_mode == MODE_ACQUIRE || in_mode == MODE_FIND);
		cmd.ld_clear = (st_q == S_IDLE) && in_fire && (in_mode == MODE_CLEAR);
		case (st_q)
			S_SCAN:  cmd.div_start = stat.scan_done && !hit_found &&
				mode_q == MODE_ACQUIRE && !tile_zero;
			S_CAP:   cmd.div_start = slot_full ? (vic_evict || (grow_ok && free_found))
				: free_found;
			S_VY:    cmd.div_start = stat.div_done;
			S_VX:    cmd.div_start = stat.div_done;
			S_GROW:  cmd.div_start = stat.div_done;
			S_TPR2:  cmd.div_start = stat.div_done;
			default: cmd.div_start = 1'b0;
		endcase
	end

	assign busy      = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign step      = st_q;
endmodule
`default_nettype wire

FILE: sv/btaa_path.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btaa_path: datapath of the tile atlas allocator
// Bucket state, generation, shared divider and result registers.
// ----------------------------------------------------------------------------
module btaa_path
	import btaa_pkg::*;
#(
	parameter int ENTRY_COUNT  = 256,
	parameter int STAMP_BITS   = 32,
	parameter int BUCKET_COUNT = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic [1:0] in_mode,
	input  wire logic [KEY_W-1:0] in_key,
	input  wire logic [SIZE_W-1:0] in_size,
	input  wire logic cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_DAT_W-1:0] cfg_dat,
	input  btaa_cmd_t cmd,
	input  wire logic [4:0] step,
	output btaa_stat_t stat,
	output logic hit_found,
	output logic free_found,
	output logic vic_evict,
	output logic tile_zero,
	output logic cap_zero,
	output logic slot_full,
	output logic grow_ok,
	output logic tpr_zero,
	output logic [STAT_W-1:0] r_status,
	output logic [1:0] r_bucket,
	output logic [COORD_W-1:0] r_x,
	output logic [COORD_W-1:0] r_y,
	output logic [TILE_W-1:0] r_edge,
	output logic r_grew,
	output logic [GEN_W-1:0] r_gen,
	output logic [EDGE_W-1:0] r_bedge
);
	localparam int BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int IDX_W = $clog2(ENTRY_COUNT);
	localparam logic [4:0] S_SCAN = 5'd1, S_TPR = 5'd2, S_CAP = 5'd3, S_VY = 5'd4,
		S_VX = 5'd5, S_GROW = 5'd6, S_TPR2 = 5'd7, S_SLOT = 5'd8, S_MULY = 5'd9,
		S_WRITE = 5'd10, S_FAIL = 5'd11, S_DONE = 5'd12, S_HIT = 5'd14;

	logic [TILE_W-1:0] tile_q [4];
	logic [EDGE_W-1:0] start_q, limit_q;
	logic [SLOT_W-1:0] nfs_q [BUCKET_COUNT];
	logic [SLOT_W-1:0] cap_q [BUCKET_COUNT];
	logic [EDGE_W-1:0] aedge_q [BUCKET_COUNT];
	logic [STAMP_BITS-1:0] gen_q;

	logic [1:0]       mode_q;
	logic [KEY_W-1:0] key_q;
	logic [BKT_W-1:0] bkt_q;
	logic [BKT_W-1:0] bkt_c;
	logic [8:0]       rounded;
	logic [TILE_W-1:0] tile;
	logic              grew_q;
	logic              evict_q;
	logic [SLOT_W-1:0] tpr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] vyq_q;
	logic [SLOT_W-1:0] sq_q;
	logic [TILE_W-1:0] sr_q;
	logic [SLOT_W-1:0] cap_eff;

	logic              div_start;
	logic [SLOT_W-1:0] div_num;
	logic [SLOT_W-1:0] div_quo;
	logic [EDGE_W-1:0] div_rem;
	logic              div_done;
	logic [EDGE_W-1:0] div_den;

	logic scan_done, s_hit, s_free, s_vic;
	logic [IDX_W-1:0] hit_idx, free_idx, vic_idx;
	logic [STAMP_BITS-1:0] vic_stamp;
	logic [COORD_W-1:0] vic_x, vic_y, hit_x, hit_y;
	logic [COORD_W-1:0] px_c, py_c;
	logic [SLOT_W+TILE_W-1:0] prod_x, prod_y;
	logic [COORD_W-1:0] wx_q, wy_q;

	function automatic logic [TILE_W-1:0] tile_for(input logic [BKT_W-1:0] b,
		input logic [TILE_W-1:0] t0, input logic [TILE_W-1:0] t1,
		input logic [TILE_W-1:0] t2, input logic [TILE_W-1:0] t3);
		logic [TILE_W-1:0] t;
		case (32'(b))
			0: t = t0;
			1: t = t1;
			2: t = t2;
			default: t = t3;
		endcase
		return t;
	endfunction

	assign rounded = 9'((17'(in_size) + 17'd128) >> 8);

	always_comb begin
		bkt_c = BKT_W'(BUCKET_COUNT - 1);
		for (int i = BUCKET_COUNT - 1; i >= 0; i--)
			if (9'(tile_for(BKT_W'(i), tile_q[0], tile_q[1], tile_q[2], tile_q[3]))
				>= rounded)
				bkt_c = BKT_W'(i);
	end

	assign tile    = tile_for(bkt_q, tile_q[0], tile_q[1], tile_q[2], tile_q[3]);
	assign tile_zero = (tile == '0);
	assign cap_eff = (cap_q[bkt_q] == '0) ? SLOT_W'(tpr_q * tpr_q) : cap_q[bkt_q];
	assign cap_zero  = (cap_q[bkt_q] == '0);
	assign slot_full = (nfs_q[bkt_q] >= cap_eff);
	assign vic_evict = s_vic && (vic_stamp < gen_q);
	assign grow_ok   = ({1'b0, aedge_q[bkt_q], 1'b0} <= {2'b00, limit_q});
	assign tpr_zero  = (tpr_q == '0);
	assign hit_found = s_hit;
	assign free_found = s_free;
	assign stat.scan_done = scan_done;
	assign stat.div_done  = div_done;

	always_comb begin
		div_num = SLOT_W'(aedge_q[bkt_q]);
		div_den = EDGE_W'(tile);
		case (step)
			S_SCAN, S_CAP: div_num = evict_q ? SLOT_W'(vic_y) : SLOT_W'(aedge_q[bkt_q]);
			S_VY:   div_num = SLOT_W'(vic_x);
			S_GROW: div_num = SLOT_W'(aedge_q[bkt_q]);
			S_TPR2: begin
				div_num = slot_q;
				div_den = tpr_q[EDGE_W-1:0];
			end
			default: div_num = SLOT_W'(aedge_q[bkt_q]);
		endcase
		if (step == S_CAP && slot_full && vic_evict)
			div_num = SLOT_W'(vic_y);
		else if (step == S_CAP && slot_full)
			div_num = SLOT_W'({aedge_q[bkt_q], 1'b0});
	end
	assign div_start = cmd.div_start;

	btaa_div #(.NUM_W(SLOT_W), .DEN_W(EDGE_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	btaa_store #(.ENTRY_COUNT(ENTRY_COUNT), .STAMP_BITS(STAMP_BITS), .BKT_W(BKT_W)) u_store (
		.clk(clk), .arst_n(arst_n), .scan_start(cmd.scan_start), .clear_all(cmd.ld_clear),
		.key(key_q), .bkt(bkt_q), .scan_done(scan_done),
		.hit_found(s_hit), .hit_idx(hit_idx), .free_found(s_free), .free_idx(free_idx),
		.vic_found(s_vic), .vic_idx(vic_idx), .vic_stamp(vic_stamp),
		.vic_x(vic_x), .vic_y(vic_y), .hit_x(hit_x), .hit_y(hit_y),
		.wr_en(step == S_WRITE), .wr_idx(evict_q ? vic_idx : free_idx),
		.wr_x(wx_q), .wr_y(wy_q), .wr_stamp(gen_q),
		.stamp_en(step == S_HIT), .stamp_idx(hit_idx),
		.inval_en(step == S_WRITE && evict_q), .inval_idx(vic_idx)
	);

	assign prod_x = SLOT_W'(div_rem) * tile;
	assign prod_y = sq_q * tile;
	assign px_c = (prod_x > (SLOT_W+TILE_W)'(COORD_MAX)) ? COORD_MAX : COORD_W'(prod_x);
	assign py_c = (prod_y > (SLOT_W+TILE_W)'(COORD_MAX)) ? COORD_MAX : COORD_W'(prod_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q[0] <= 8'd16;
			tile_q[1] <= 8'd32;
			tile_q[2] <= 8'd64;
			tile_q[3] <= 8'd128;
			start_q   <= 13'd512;
			limit_q   <= 13'd4096;
			gen_q     <= '0;
			for (int b = 0; b < BUCKET_COUNT; b++) begin
				nfs_q[b]   <= '0;
				cap_q[b]   <= '0;
				aedge_q[b] <= 13'd512;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TILE0: tile_q[0] <= cfg_dat[TILE_W-1:0];
					REG_TILE1: tile_q[1] <= cfg_dat[TILE_W-1:0];
					REG_TILE2: tile_q[2] <= cfg_dat[TILE_W-1:0];
					REG_TILE3: tile_q[3] <= cfg_dat[TILE_W-1:0];
					REG_START: start_q <= cfg_dat;
					REG_LIMIT: limit_q <= cfg_dat;
					default: ;
				endcase
			end
			if (in_fire && in_mode == MODE_ADVANCE)
				gen_q <= gen_q + 1'b1;
			if (in_fire && in_mode == MODE_CLEAR) begin
				for (int b = 0; b < BUCKET_COUNT; b++) begin
					nfs_q[b]   <= '0;
					cap_q[b]   <= '0;
					aedge_q[b] <= start_q;
				end
			end
			if (step == S_CAP && cap_q[bkt_q] == '0)
				cap_q[bkt_q] <= SLOT_W'(tpr_q * tpr_q);
			if (step == S_GROW && div_done)
				cap_q[bkt_q] <= SLOT_W'(div_quo * div_quo);
			if (step == S_CAP && slot_full && !vic_evict && grow_ok && s_free)
				aedge_q[bkt_q] <= EDGE_W'({aedge_q[bkt_q], 1'b0});
			if (step == S_SLOT && !tpr_zero && div_done && !evict_q)
				nfs_q[bkt_q] <= nfs_q[bkt_q] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= in_mode;
			key_q   <= in_key;
			bkt_q   <= bkt_c;
			grew_q  <= 1'b0;
			evict_q <= 1'b0;
		end
		case (step)
			S_TPR: if (div_done) tpr_q <= div_quo;
			S_CAP: begin
				if (slot_full && vic_evict)
					evict_q <= 1'b1;
				else if (slot_full && grow_ok && s_free)
					grew_q <= 1'b1;
				slot_q <= nfs_q[bkt_q];
			end
			S_VY:   if (div_done) vyq_q <= div_quo;
			S_VX:   if (div_done) slot_q <= SLOT_W'(vyq_q * tpr_q) + div_quo;
			S_TPR2: if (div_done) tpr_q <= div_quo;
			S_SLOT: if (div_done) begin
				sq_q <= div_quo;
				wx_q <= px_c;
			end
			S_MULY: wy_q <= py_c;
			default: ;
		endcase
		if (step == S_GROW && div_done)
			tpr_q <= div_quo;
	end

	always_ff @(posedge clk) begin
		r_bucket <= 2'(bkt_q);
		r_gen    <= GEN_W'(gen_q);
		r_bedge  <= aedge_q[bkt_q];
		r_grew   <= grew_q;
		case (step)
			S_WRITE: begin
				r_status <= ST_PLACED;
				r_x <= wx_q;
				r_y <= wy_q;
				r_edge <= tile;
			end
			S_HIT: begin
				r_status <= (mode_q == MODE_FIND) ? ST_FOUND : ST_STORED;
				r_x <= (mode_q == MODE_FIND) ? hit_x : '0;
				r_y <= (mode_q == MODE_FIND) ? hit_y : '0;
				r_edge <= (mode_q == MODE_FIND) ? tile : '0;
			end
			S_FAIL, S_DONE: begin
				r_status <= (step == S_FAIL) ? ST_NO_ROOM
					: (mode_q == MODE_FIND) ? ST_NOT_FOUND : ST_DONE;
				r_x <= '0;
				r_y <= '0;
				r_edge <= '0;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: sv/bucketed_tile_atlas_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_tile_atlas_allocator: glyph tile cache with generational eviction
//
// Requests arrive on a valid/ready input channel: acquire, find, advance
// generation or clear. Each request gives one result on the output channel.
// Configuration registers (tile edges, start and limit atlas edge) are
// written through a plain write port, by the user only while the block is
// idle; the block itself does not enforce it. Acquire and find scan every
// entry once, one entry per cycle, and acquire adds up to five serial
// divisions on the shared divider; advance and clear go straight to their
// result. One request is in flight at a time.
// Reset clears the valid bits, buckets and generation at once; no sweep.
// The result is held in the output register until the receiver takes it;
// input ready stays low until then.
// ----------------------------------------------------------------------------
module bucketed_tile_atlas_allocator
	import btaa_pkg::*;
#(
	parameter int BUCKET_COUNT = 4,
	parameter int ENTRY_COUNT  = 256,
	parameter int STAMP_BITS   = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	btaa_in_if.sink   in_ch,
	btaa_out_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);
	btaa_cmd_t  cmd;
	btaa_stat_t stat;
	logic busy, in_fire, out_fire;
	logic hit_found, free_found, vic_evict, tile_zero, cap_zero, slot_full;
	logic grow_ok, tpr_zero;
	logic [4:0] step;

	assign in_ch.ready = !busy;
	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	btaa_ctrl #(.ENTRY_COUNT(ENTRY_COUNT), .STAMP_BITS(STAMP_BITS),
		.BUCKET_COUNT(BUCKET_COUNT)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_mode(in_ch.mode),
		.out_fire(out_fire), .hit_found(hit_found), .free_found(free_found),
		.vic_evict(vic_evict), .tile_zero(tile_zero), .cap_zero(cap_zero),
		.slot_full(slot_full), .grow_ok(grow_ok), .tpr_zero(tpr_zero),
		.stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_ch.valid), .step(step)
	);

	btaa_path #(.ENTRY_COUNT(ENTRY_COUNT), .STAMP_BITS(STAMP_BITS),
		.BUCKET_COUNT(BUCKET_COUNT)) u_path (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_mode(in_ch.mode),
		.in_key(in_ch.glyph_key), .in_size(in_ch.size_fixed),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_dat(cfg_data),
		.cmd(cmd), .step(step), .stat(stat),
		.hit_found(hit_found), .free_found(free_found), .vic_evict(vic_evict),
		.tile_zero(tile_zero), .cap_zero(cap_zero), .slot_full(slot_full),
		.grow_ok(grow_ok), .tpr_zero(tpr_zero),
		.r_status(out_ch.status), .r_bucket(out_ch.bucket_index),
		.r_x(out_ch.pos_x), .r_y(out_ch.pos_y), .r_edge(out_ch.tile_edge),
		.r_grew(out_ch.grew_flag), .r_gen(out_ch.current_generation),
		.r_bedge(out_ch.bucket_edge)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input accepted while result pending");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> busy)
		else $error("scan started without busy");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |=> !out_ch.valid)
		else $error("result repeated");
endmodule
`default_nettype wire
